>>> rtl/core/conveyor_color_sorter_sequencer_assert.svh
// Assertion macros for the conveyor color sorter sequencer.
// Clocked on clk, disabled while arst_n is low; empty bodies under SYNTHESIS.
`ifndef CONVEYOR_COLOR_SORTER_SEQUENCER_ASSERT_SVH
`define CONVEYOR_COLOR_SORTER_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
// plain property, checked at every clock edge out of reset
`define CCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// same-cycle implication
`define CCS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define CCS_ASSERT(lbl, prop, msg)
`define CCS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/core/ccs_pkg.sv
// Shared types and constants of the conveyor color sorter sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package ccs_pkg;

	// fixed field widths
	localparam int COLOR_W = 14;
	localparam int DIST_W  = 8;
	localparam int HOLD_W  = 16;

	// stream and register port widths
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;
	localparam int APB_ADDR_W  = 5;
	localparam int APB_DATA_W  = 32;

	// sequencer phases
	localparam logic [2:0] PH_WAIT  = 3'd0;
	localparam logic [2:0] PH_SENSE = 3'd1;
	localparam logic [2:0] PH_COUNT = 3'd2;
	localparam logic [2:0] PH_EJECT = 3'd3;
	localparam logic [2:0] PH_ARM   = 3'd4;

	// part colors
	localparam logic [1:0] COL_WHITE = 2'd0;
	localparam logic [1:0] COL_RED   = 2'd1;
	localparam logic [1:0] COL_BLUE  = 2'd2;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_WHITE_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_RED_THRESHOLD   = 3'd1;
	localparam logic [2:0] REG_WHITE_DISTANCE  = 3'd2;
	localparam logic [2:0] REG_RED_DISTANCE    = 3'd3;
	localparam logic [2:0] REG_BLUE_DISTANCE   = 3'd4;
	localparam logic [2:0] REG_EJECT_HOLD      = 3'd5;
	localparam logic [2:0] REG_MIN_START       = 3'd6;

	// register reset values
	localparam logic [COLOR_W-1:0] WHITE_THRESHOLD_RST = 14'd2500;
	localparam logic [COLOR_W-1:0] RED_THRESHOLD_RST   = 14'd4600;
	localparam logic [DIST_W-1:0]  WHITE_DISTANCE_RST  = 8'd3;
	localparam logic [DIST_W-1:0]  RED_DISTANCE_RST    = 8'd9;
	localparam logic [DIST_W-1:0]  BLUE_DISTANCE_RST   = 8'd14;
	localparam logic [HOLD_W-1:0]  EJECT_HOLD_RST      = 16'd1500;
	localparam logic [COLOR_W-1:0] MIN_START_RST       = 14'd10000;

	typedef struct packed {
		logic [COLOR_W-1:0] white_threshold;
		logic [COLOR_W-1:0] red_threshold;
		logic [DIST_W-1:0]  white_distance;
		logic [DIST_W-1:0]  red_distance;
		logic [DIST_W-1:0]  blue_distance;
		logic [HOLD_W-1:0]  eject_hold_ticks;
		logic [COLOR_W-1:0] min_start_value;
	} cfg_t;

	typedef struct packed {
		logic               entry_barrier_level;
		logic               exit_barrier_level;
		logic               pulse_key_level;
		logic [COLOR_W-1:0] color_reading;
		logic               white_bay_level;
		logic               red_bay_level;
		logic               blue_bay_level;
	} in_item_t;

	typedef struct packed {
		logic       conveyor_on;
		logic       compressor_on;
		logic       eject_white;
		logic       eject_red;
		logic       eject_blue;
		logic       arm_request;
		logic [1:0] sorted_color;
		logic [2:0] phase;
	} out_item_t;

endpackage

`default_nettype wire

>>> rtl/core/ccs_apb_regs.sv
// APB configuration registers of the conveyor color sorter sequencer.
// Depends on ccs_pkg for register indexes, widths and reset values.
`default_nettype none

module ccs_apb_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ccs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ccs_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ccs_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output ccs_pkg::cfg_t                   cfg
);
	import ccs_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// register writes, truncated to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.white_threshold  <= WHITE_THRESHOLD_RST;
			cfg_q.red_threshold    <= RED_THRESHOLD_RST;
			cfg_q.white_distance   <= WHITE_DISTANCE_RST;
			cfg_q.red_distance     <= RED_DISTANCE_RST;
			cfg_q.blue_distance    <= BLUE_DISTANCE_RST;
			cfg_q.eject_hold_ticks <= EJECT_HOLD_RST;
			cfg_q.min_start_value  <= MIN_START_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WHITE_THRESHOLD: cfg_q.white_threshold  <= pwdata[COLOR_W-1:0];
				REG_RED_THRESHOLD:   cfg_q.red_threshold    <= pwdata[COLOR_W-1:0];
				REG_WHITE_DISTANCE:  cfg_q.white_distance   <= pwdata[DIST_W-1:0];
				REG_RED_DISTANCE:    cfg_q.red_distance     <= pwdata[DIST_W-1:0];
				REG_BLUE_DISTANCE:   cfg_q.blue_distance    <= pwdata[DIST_W-1:0];
				REG_EJECT_HOLD:      cfg_q.eject_hold_ticks <= pwdata[HOLD_W-1:0];
				REG_MIN_START:       cfg_q.min_start_value  <= pwdata[COLOR_W-1:0];
				default: ; // unmapped address, write dropped
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_WHITE_THRESHOLD: prdata = APB_DATA_W'(cfg_q.white_threshold);
			REG_RED_THRESHOLD:   prdata = APB_DATA_W'(cfg_q.red_threshold);
			REG_WHITE_DISTANCE:  prdata = APB_DATA_W'(cfg_q.white_distance);
			REG_RED_DISTANCE:    prdata = APB_DATA_W'(cfg_q.red_distance);
			REG_BLUE_DISTANCE:   prdata = APB_DATA_W'(cfg_q.blue_distance);
			REG_EJECT_HOLD:      prdata = APB_DATA_W'(cfg_q.eject_hold_ticks);
			REG_MIN_START:       prdata = APB_DATA_W'(cfg_q.min_start_value);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/ccs_sequencer.sv
// Sorting sequencer state and single-tick step logic.
// Depends on ccs_pkg and the assertion macro header.
`default_nettype none
`include "conveyor_color_sorter_sequencer_assert.svh"

module ccs_sequencer #(
	parameter int COLOR_BITS    = 14,
	parameter int DISTANCE_BITS = 8,
	parameter int HOLD_BITS     = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  ccs_pkg::cfg_t        cfg,
	input  ccs_pkg::in_item_t    item,
	output ccs_pkg::out_item_t   result
);
	import ccs_pkg::*;

	localparam logic [31:0] COLOR_MAX = 32'((64'd1 << COLOR_BITS) - 64'd1);
	localparam logic [31:0] DIST_MAX  = 32'((64'd1 << DISTANCE_BITS) - 64'd1);
	localparam logic [31:0] HOLD_MAX  = 32'((64'd1 << HOLD_BITS) - 64'd1);

	function automatic logic [COLOR_BITS-1:0] sat_color(input logic [31:0] v);
		logic [31:0] c;
		c = (v > COLOR_MAX) ? COLOR_MAX : v;
		return c[COLOR_BITS-1:0];
	endfunction

	function automatic logic [DISTANCE_BITS-1:0] sat_dist(input logic [31:0] v);
		logic [31:0] c;
		c = (v > DIST_MAX) ? DIST_MAX : v;
		return c[DISTANCE_BITS-1:0];
	endfunction

	function automatic logic [HOLD_BITS-1:0] sat_hold(input logic [31:0] v);
		logic [31:0] c;
		c = (v > HOLD_MAX) ? HOLD_MAX : v;
		return c[HOLD_BITS-1:0];
	endfunction

	// state
	logic [2:0]               phase_q,  phase_n;
	logic [COLOR_BITS-1:0]    rmin_q,   rmin_n;
	logic [DISTANCE_BITS-1:0] tdist_q,  tdist_n;
	logic [DISTANCE_BITS-1:0] dcount_q, dcount_n;
	logic                     prev_q,   prev_n;
	logic [1:0]               tcolor_q, tcolor_n;
	logic [HOLD_BITS-1:0]     hold_q,   hold_n;
	logic                     belt_q,   belt_n;
	logic                     comp_q,   comp_n;

	logic [COLOR_BITS-1:0] color_sat;
	logic [1:0]            sel;
	logic [2:0]            bay;
	logic [2:0]            ej;
	logic                  arm;

	assign color_sat = sat_color(32'(item.color_reading));
	// an unused color code acts as blue
	assign sel = (tcolor_q > COL_BLUE) ? COL_BLUE : tcolor_q;
	assign bay = {item.blue_bay_level, item.red_bay_level, item.white_bay_level};

	// one tick of the sequencer
	always_comb begin
		phase_n  = phase_q;
		rmin_n   = rmin_q;
		tdist_n  = tdist_q;
		dcount_n = dcount_q;
		prev_n   = prev_q;
		tcolor_n = tcolor_q;
		hold_n   = hold_q;
		belt_n   = belt_q;
		comp_n   = comp_q;
		ej       = 3'b000;
		arm      = 1'b0;
		unique case (phase_q)
			PH_SENSE: begin
				rmin_n = (color_sat < rmin_q) ? color_sat : rmin_q;
				if (!item.exit_barrier_level) begin
					dcount_n = '0;
					if (32'(rmin_n) < 32'(cfg.white_threshold)) begin
						tdist_n  = sat_dist(32'(cfg.white_distance));
						tcolor_n = COL_WHITE;
					end else if (32'(rmin_n) < 32'(cfg.red_threshold)) begin
						tdist_n  = sat_dist(32'(cfg.red_distance));
						tcolor_n = COL_RED;
					end else begin
						tdist_n  = sat_dist(32'(cfg.blue_distance));
						tcolor_n = COL_BLUE;
					end
					comp_n  = 1'b1;
					phase_n = PH_COUNT;
				end
			end
			PH_COUNT: begin
				// rising pulse-key edge, count saturates
				if (item.pulse_key_level && !prev_q && (32'(dcount_q) < DIST_MAX)) begin
					dcount_n = dcount_q + DISTANCE_BITS'(1);
				end
				prev_n = item.pulse_key_level;
				if (dcount_n >= tdist_q) begin
					belt_n = 1'b0;
					hold_n = sat_hold(32'(cfg.eject_hold_ticks));
					if (hold_n == '0) begin
						hold_n = HOLD_BITS'(1);
					end
					phase_n = PH_EJECT;
				end
			end
			PH_EJECT: begin
				ej[sel] = 1'b1;
				if (hold_q <= HOLD_BITS'(1)) begin
					hold_n  = '0;
					phase_n = PH_ARM;
				end else begin
					hold_n = hold_q - HOLD_BITS'(1);
				end
			end
			PH_ARM: begin
				if (!bay[sel]) begin
					arm     = 1'b1;
					phase_n = PH_WAIT;
				end
			end
			default: begin
				// waiting, or a code that means nothing
				phase_n = PH_WAIT;
				if (!item.entry_barrier_level) begin
					belt_n  = 1'b1;
					rmin_n  = sat_color(32'(cfg.min_start_value));
					phase_n = PH_SENSE;
				end
			end
		endcase
	end

	// state update on each processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_WAIT;
			rmin_q   <= sat_color(32'(MIN_START_RST));
			tdist_q  <= '0;
			dcount_q <= '0;
			prev_q   <= 1'b0;
			tcolor_q <= COL_BLUE;
			hold_q   <= '0;
			belt_q   <= 1'b0;
			comp_q   <= 1'b0;
		end else if (en) begin
			phase_q  <= phase_n;
			rmin_q   <= rmin_n;
			tdist_q  <= tdist_n;
			dcount_q <= dcount_n;
			prev_q   <= prev_n;
			tcolor_q <= tcolor_n;
			hold_q   <= hold_n;
			belt_q   <= belt_n;
			comp_q   <= comp_n;
		end
	end

	// result reflects the state after this tick
	assign result.conveyor_on   = belt_n;
	assign result.compressor_on = comp_n;
	assign result.eject_white   = ej[0];
	assign result.eject_red     = ej[1];
	assign result.eject_blue    = ej[2];
	assign result.arm_request   = arm;
	assign result.sorted_color  = tcolor_n;
	assign result.phase         = phase_n;

	// checks
	`CCS_ASSERT(a_one_ejector, $onehot0(ej), "more than one ejector driven")
	`CCS_ASSERT_IMPL(a_belt_stopped, (phase_q == PH_EJECT) || (phase_q == PH_ARM), !belt_q, "belt running while ejecting or waiting for arm")
	`CCS_ASSERT_IMPL(a_hold_live, phase_q == PH_EJECT, hold_q != '0, "ejecting with an empty hold timer")
	`CCS_ASSERT(a_comp_latched, !$fell(comp_q), "compressor latch dropped")
	`CCS_ASSERT_IMPL(a_arm_from_wait, arm, phase_q == PH_ARM, "arm request outside arm wait")

endmodule

`default_nettype wire

>>> rtl/core/conveyor_color_sorter_sequencer.sv
// Top level of the conveyor color sorter sequencer: stream stages around the step logic.
// Depends on ccs_pkg, ccs_apb_regs and ccs_sequencer.
`default_nettype none

// One input beat is one sensor sample tick and yields exactly one result beat
// carrying the drive outputs after that tick. The block takes a beat every cycle
// while the output keeps up: a beat lands in an input register, one pass of
// compare-and-count logic updates the sequencer state and fills the output register
// once that register is free, and the result leaves when the output side is ready.
// The output register lets a new beat enter while a result waits; backpressure
// from the output stalls the input once both registers are full.
// Configuration writes go through the APB port and should be made while no
// beats are in flight.
module conveyor_color_sorter_sequencer #(
	parameter int COLOR_BITS    = 14,
	parameter int DISTANCE_BITS = 8,
	parameter int HOLD_BITS     = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// APB configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ccs_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [ccs_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [ccs_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	// sensor samples
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [0] entry_barrier_level, [1] exit_barrier_level, [2] pulse_key_level,
	// [16:3] color_reading, [17] white_bay_level, [18] red_bay_level,
	// [19] blue_bay_level, [23:20] zero
	input  logic [ccs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// drive outputs
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [0] conveyor_on, [1] compressor_on, [2] eject_white, [3] eject_red,
	// [4] eject_blue, [5] arm_request, [7:6] sorted_color, [10:8] phase,
	// [15:11] zero
	output logic [ccs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import ccs_pkg::*;

	cfg_t      cfg;
	in_item_t  in_item;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t out_q;
	logic      out_valid_q;
	logic      advance;
	logic      in_beat;

	ccs_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// unpack input beat
	assign in_item.entry_barrier_level = s_axis_tdata[0];
	assign in_item.exit_barrier_level  = s_axis_tdata[1];
	assign in_item.pulse_key_level     = s_axis_tdata[2];
	assign in_item.color_reading       = s_axis_tdata[COLOR_W+2:3];
	assign in_item.white_bay_level     = s_axis_tdata[COLOR_W+3];
	assign in_item.red_bay_level       = s_axis_tdata[COLOR_W+4];
	assign in_item.blue_bay_level      = s_axis_tdata[COLOR_W+5];

	// handshake: step runs when a beat is held and the output slot is free
	assign advance       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;
	assign in_beat       = s_axis_tvalid & s_axis_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			item_s1 <= in_item;
		end
	end

	ccs_sequencer #(
		.COLOR_BITS    (COLOR_BITS),
		.DISTANCE_BITS (DISTANCE_BITS),
		.HOLD_BITS     (HOLD_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.result (result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, out_q.phase, out_q.sorted_color, out_q.arm_request,
		out_q.eject_blue, out_q.eject_red, out_q.eject_white,
		out_q.compressor_on, out_q.conveyor_on};

endmodule

`default_nettype wire

>>> tb/sv/tb_conveyor_color_sorter_sequencer.sv
// Self-checking testbench for the conveyor color sorter sequencer: APB register setup,
// sensor tick beats in, drive output beats checked against an in-bench sequencer model.
// Depends on ccs_pkg and conveyor_color_sorter_sequencer.
`timescale 1ns / 100ps

module tb_conveyor_color_sorter_sequencer;
	import ccs_pkg::*;

	// register index with no register behind it
	localparam logic [2:0] REG_UNMAPPED = 3'd7;
	localparam logic [COLOR_W-1:0] COLOR_TOP = '1;
	localparam logic [DIST_W-1:0]  DIST_TOP  = '1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// [0] entry, [1] exit, [2] pulse key, [16:3] color, [17] white bay, [18] red bay,
	// [19] blue bay, [23:20] zero
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// [0] conveyor, [1] compressor, [2] eject white, [3] eject red, [4] eject blue,
	// [5] arm request, [7:6] sorted color, [10:8] phase, [15:11] zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	conveyor_color_sorter_sequencer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// sequencer model state and its copy of the registers
	cfg_t               cfg;
	logic [2:0]         seq_phase;
	logic [COLOR_W-1:0] run_min;
	logic [DIST_W-1:0]  tgt_dist;
	logic [DIST_W-1:0]  edge_count;
	logic               last_pulse;
	logic [1:0]         tgt_color;
	logic [HOLD_W-1:0]  eject_timer;
	logic               belt_on;
	logic               comp_latched;
	int unsigned        parts_done;

	out_item_t drive_expected[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int holdoff_cycles = 0;

	function automatic void reset_sequencer_model();
		cfg.white_threshold  = WHITE_THRESHOLD_RST;
		cfg.red_threshold    = RED_THRESHOLD_RST;
		cfg.white_distance   = WHITE_DISTANCE_RST;
		cfg.red_distance     = RED_DISTANCE_RST;
		cfg.blue_distance    = BLUE_DISTANCE_RST;
		cfg.eject_hold_ticks = EJECT_HOLD_RST;
		cfg.min_start_value  = MIN_START_RST;
		seq_phase    = PH_WAIT;
		run_min      = MIN_START_RST;
		tgt_dist     = '0;
		edge_count   = '0;
		last_pulse   = 1'b0;
		tgt_color    = COL_BLUE;
		eject_timer  = '0;
		belt_on      = 1'b0;
		comp_latched = 1'b0;
		parts_done   = 0;
	endfunction

	// one sample tick through the sequencer; returns the drive outputs after it
	function automatic out_item_t advance_sequencer(in_item_t t);
		out_item_t r;
		logic [1:0] sel;
		logic bay;
		r = '0;
		sel = (tgt_color > COL_BLUE) ? COL_BLUE : tgt_color;
		case (seq_phase)
			PH_SENSE: begin
				if (t.color_reading < run_min)
					run_min = t.color_reading;
				if (!t.exit_barrier_level) begin
					edge_count = '0;
					if (run_min < cfg.white_threshold) begin
						tgt_dist = cfg.white_distance;
						tgt_color = COL_WHITE;
					end else if (run_min < cfg.red_threshold) begin
						tgt_dist = cfg.red_distance;
						tgt_color = COL_RED;
					end else begin
						tgt_dist = cfg.blue_distance;
						tgt_color = COL_BLUE;
					end
					comp_latched = 1'b1;
					seq_phase = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (t.pulse_key_level && !last_pulse && edge_count != DIST_TOP)
					edge_count = edge_count + DIST_W'(1);
				last_pulse = t.pulse_key_level;
				if (edge_count >= tgt_dist) begin
					belt_on = 1'b0;
					eject_timer = (cfg.eject_hold_ticks == '0) ? HOLD_W'(1)
						: cfg.eject_hold_ticks;
					seq_phase = PH_EJECT;
				end
			end
			PH_EJECT: begin
				case (sel)
					COL_WHITE: r.eject_white = 1'b1;
					COL_RED:   r.eject_red = 1'b1;
					default:   r.eject_blue = 1'b1;
				endcase
				if (eject_timer <= HOLD_W'(1)) begin
					eject_timer = '0;
					seq_phase = PH_ARM;
				end else begin
					eject_timer = eject_timer - HOLD_W'(1);
				end
			end
			PH_ARM: begin
				case (sel)
					COL_WHITE: bay = t.white_bay_level;
					COL_RED:   bay = t.red_bay_level;
					default:   bay = t.blue_bay_level;
				endcase
				if (!bay) begin
					r.arm_request = 1'b1;
					seq_phase = PH_WAIT;
					parts_done++;
				end
			end
			default: begin
				seq_phase = PH_WAIT;
				if (!t.entry_barrier_level) begin
					belt_on = 1'b1;
					run_min = cfg.min_start_value;
					seq_phase = PH_SENSE;
				end
			end
		endcase
		r.conveyor_on   = belt_on;
		r.compressor_on = comp_latched;
		r.sorted_color  = tgt_color;
		r.phase         = seq_phase;
		return r;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_sample(in_item_t t);
		return {4'b0, t.blue_bay_level, t.red_bay_level, t.white_bay_level,
			t.color_reading, t.pulse_key_level, t.exit_barrier_level, t.entry_barrier_level};
	endfunction

	// readings spread over the range and bunched around the thresholds
	function automatic logic [COLOR_W-1:0] pick_color();
		int v;
		case ($urandom_range(4))
			0: v = int'(cfg.white_threshold) + $urandom_range(4) - 2;
			1: v = int'(cfg.red_threshold) + $urandom_range(4) - 2;
			2: v = $urandom_range(1) ? int'(COLOR_TOP) : 0;
			default: v = $urandom_range(int'(COLOR_TOP));
		endcase
		if (v < 0)
			v = 0;
		if (v > int'(COLOR_TOP))
			v = int'(COLOR_TOP);
		return v[COLOR_W-1:0];
	endfunction

	// next sensor sample, shaped by the model phase so parts get all the way through
	function automatic in_item_t next_sample();
		in_item_t t;
		logic [1:0] sel;
		t.entry_barrier_level = $urandom_range(1);
		t.exit_barrier_level  = $urandom_range(1);
		t.pulse_key_level     = $urandom_range(1);
		t.color_reading       = pick_color();
		t.white_bay_level     = $urandom_range(1);
		t.red_bay_level       = $urandom_range(1);
		t.blue_bay_level      = $urandom_range(1);
		// about one sample in ten stays pure noise
		if ($urandom_range(99) < 10)
			return t;
		sel = (tgt_color > COL_BLUE) ? COL_BLUE : tgt_color;
		case (seq_phase)
			PH_WAIT:  t.entry_barrier_level = ($urandom_range(99) >= 35);
			PH_SENSE: t.exit_barrier_level = ($urandom_range(99) >= 20);
			PH_COUNT: t.pulse_key_level = ($urandom_range(99) < 70) ? !last_pulse : last_pulse;
			PH_ARM: begin
				case (sel)
					COL_WHITE: t.white_bay_level = ($urandom_range(99) >= 35);
					COL_RED:   t.red_bay_level = ($urandom_range(99) >= 35);
					default:   t.blue_bay_level = ($urandom_range(99) >= 35);
				endcase
			end
			default: ;
		endcase
		return t;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < 40)
			$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// offer one tick beat, with a random gap ahead of it; model advances on acceptance
	task automatic send_tick(input in_item_t t);
		int gap;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pack_sample(t);
		do @(posedge clk); while (!s_axis_tready);
		drive_expected.push_back(advance_sequencer(t));
	endtask

	task automatic tick(input logic entry, input logic exitb, input logic pulse,
			input int color, input logic wbay, input logic rbay, input logic bbay);
		in_item_t t;
		t.entry_barrier_level = entry;
		t.exit_barrier_level  = exitb;
		t.pulse_key_level     = pulse;
		t.color_reading       = color[COLOR_W-1:0];
		t.white_bay_level     = wbay;
		t.red_bay_level       = rbay;
		t.blue_bay_level      = bbay;
		send_tick(t);
	endtask

	task automatic run_ticks(input int n);
		repeat (n) send_tick(next_sample());
	endtask

	task automatic run_parts(input int n);
		int unsigned goal;
		goal = parts_done + n;
		while (parts_done < goal)
			send_tick(next_sample());
	endtask

	// stop offering and let every expected beat come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (drive_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, access cycle, then a quiet gap with psel low
	task automatic write_reg(input logic [2:0] idx, input int unsigned value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WHITE_THRESHOLD: cfg.white_threshold = value[COLOR_W-1:0];
			REG_RED_THRESHOLD:   cfg.red_threshold = value[COLOR_W-1:0];
			REG_WHITE_DISTANCE:  cfg.white_distance = value[DIST_W-1:0];
			REG_RED_DISTANCE:    cfg.red_distance = value[DIST_W-1:0];
			REG_BLUE_DISTANCE:   cfg.blue_distance = value[DIST_W-1:0];
			REG_EJECT_HOLD:      cfg.eject_hold_ticks = value[HOLD_W-1:0];
			REG_MIN_START:       cfg.min_start_value = value[COLOR_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_setup(input int wthr, input int rthr, input int wdist,
			input int rdist, input int bdist, input int hold, input int mstart);
		write_reg(REG_WHITE_THRESHOLD, wthr);
		write_reg(REG_RED_THRESHOLD, rthr);
		write_reg(REG_WHITE_DISTANCE, wdist);
		write_reg(REG_RED_DISTANCE, rdist);
		write_reg(REG_BLUE_DISTANCE, bdist);
		write_reg(REG_EJECT_HOLD, hold);
		write_reg(REG_MIN_START, mstart);
	endtask

	// short distances and holds keep parts moving; thresholds anywhere
	task automatic program_random_setup();
		int wthr;
		int rthr;
		wthr = $urandom_range(int'(COLOR_TOP));
		rthr = $urandom_range(1) ? $urandom_range(wthr, int'(COLOR_TOP))
			: $urandom_range(int'(COLOR_TOP));
		program_setup(wthr, rthr, $urandom_range(12), $urandom_range(12),
			$urandom_range(12), $urandom_range(1, 12),
			$urandom_range(1) ? int'(COLOR_TOP) : $urandom_range(int'(COLOR_TOP)));
	endtask

	// receiver: random stalls, or a counted hold-off when a test asks for one
	always @(posedge clk) begin
		if (holdoff_cycles > 0) begin
			m_axis_tready <= 1'b0;
			holdoff_cycles--;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch(name, got, want);
	endtask

	// compare each output beat with the oldest expectation
	always @(posedge clk) begin : result_monitor
		out_item_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (drive_expected.size() == 0) begin
				report_mismatch("unexpected beat, tdata", m_axis_tdata, 0);
			end else begin
				want = drive_expected.pop_front();
				check_field("conveyor_on", m_axis_tdata[0], want.conveyor_on);
				check_field("compressor_on", m_axis_tdata[1], want.compressor_on);
				check_field("eject_white", m_axis_tdata[2], want.eject_white);
				check_field("eject_red", m_axis_tdata[3], want.eject_red);
				check_field("eject_blue", m_axis_tdata[4], want.eject_blue);
				check_field("arm_request", m_axis_tdata[5], want.arm_request);
				check_field("sorted_color", m_axis_tdata[7:6], want.sorted_color);
				check_field("phase", m_axis_tdata[10:8], want.phase);
			end
		end
	end

	// three parts by hand: white with zero distance and zero hold, blue, red
	task automatic test_directed();
		program_setup(WHITE_THRESHOLD_RST, RED_THRESHOLD_RST, 0, 2, 1, 0, MIN_START_RST);
		tick(1, 1, 0, 100, 1, 1, 1);
		tick(0, 1, 0, 5000, 1, 1, 1);
		tick(1, 1, 0, 16383, 1, 1, 1);
		tick(1, 0, 0, 0, 1, 1, 1);
		tick(1, 1, 0, 50, 1, 1, 1);
		tick(1, 1, 0, 50, 0, 0, 0);
		// selected bay occupied, then wrong bays occupied with the selected one clear
		tick(1, 1, 0, 50, 1, 0, 0);
		tick(0, 1, 0, 50, 0, 1, 1);
		tick(0, 1, 0, 9000, 1, 1, 1);
		tick(1, 0, 1, 16383, 1, 1, 1);
		tick(1, 1, 1, 0, 1, 1, 1);
		tick(1, 1, 1, 0, 1, 1, 1);
		tick(1, 1, 0, 0, 0, 0, 0);
		tick(0, 1, 0, 7000, 1, 1, 1);
		tick(1, 1, 0, 3000, 1, 1, 1);
		tick(1, 0, 0, 16383, 1, 1, 1);
		// key still high from the last part: no edge
		tick(1, 1, 1, 0, 1, 1, 1);
		tick(1, 1, 0, 0, 1, 1, 1);
		tick(1, 1, 1, 0, 1, 1, 1);
		tick(1, 1, 0, 0, 1, 1, 1);
		tick(1, 1, 1, 0, 1, 1, 1);
		tick(1, 1, 1, 0, 1, 1, 1);
		tick(1, 1, 1, 0, 1, 0, 1);
		wait_drained();
	endtask

	task automatic test_register_extremes();
		// everything blue, immediate stop, start value at the floor
		program_setup(0, 0, 0, 0, 0, 1, 0);
		run_parts(3);
		wait_drained();
		// thresholds at the top, full white distance
		program_setup(COLOR_TOP, COLOR_TOP, DIST_TOP, 2, 2, 2, COLOR_TOP);
		run_parts(1);
		wait_drained();
		// a write to the unmapped slot changes nothing
		write_reg(REG_UNMAPPED, $urandom);
		program_setup(COLOR_TOP, COLOR_TOP, 4, DIST_TOP, DIST_TOP, 3, $urandom_range(16383));
		run_parts(3);
		wait_drained();
	endtask

	task automatic test_long_hold();
		send_idle_pct = 0;
		stall_pct = 0;
		program_setup(WHITE_THRESHOLD_RST, RED_THRESHOLD_RST, 1, 1, 1, 300, MIN_START_RST);
		run_parts(1);
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		program_random_setup();
		holdoff_cycles = 300;
		run_ticks(80);
		wait_drained();
	endtask

	task automatic test_idle_mixes();
		int sidle[4] = '{0, 72, 0, 34};
		int rstall[4] = '{0, 0, 72, 34};
		for (int m = 0; m < 4; m++) begin
			send_idle_pct = sidle[m];
			stall_pct = rstall[m];
			program_random_setup();
			run_ticks(160);
			wait_drained();
		end
	endtask

	initial begin
		reset_sequencer_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_register_extremes();
		test_long_hold();
		test_backpressure();
		test_idle_mixes();
		wait_drained();
		repeat (8) @(posedge clk);
		if (drive_expected.size() != 0)
			report_mismatch("beats never returned", 0, drive_expected.size());
		if (mismatch_count == 0)
			$display("PASS conveyor_color_sorter_sequencer");
		else
			$display("FAIL conveyor_color_sorter_sequencer");
		$finish;
	end

	// run limit, several times the slowest passing run
	initial begin
		#(1_000_000);
		$display("FAIL conveyor_color_sorter_sequencer");
		$finish;
	end

endmodule

>>> conveyor_color_sorter_sequencer.f
+incdir+rtl/core
rtl/core/ccs_pkg.sv
rtl/core/ccs_apb_regs.sv
rtl/core/ccs_sequencer.sv
rtl/core/conveyor_color_sorter_sequencer.sv
tb/sv/tb_conveyor_color_sorter_sequencer.sv
